// ----- rtl/core/hrd_pkg.sv -----
// Shared types, character codes and digit decode for the hex record data decoder.
package hrd_pkg;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned UPPER_W  = 16;
    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned HWORD_W  = 16;
    localparam int unsigned POS_W    = 10;
    localparam int unsigned ACC_W    = 12;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned INDEX_W  = 7;

    localparam logic [CHAR_W-1:0] CHAR_COLON  = 8'd58;
    localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'd57;
    localparam logic [CHAR_W-1:0] CHAR_UPPERA = 8'd65;
    localparam logic [CHAR_W-1:0] CHAR_UPPERF = 8'd70;
    localparam logic [CHAR_W-1:0] ALPHA_BIAS  = 8'd55;

    localparam logic [POS_W-1:0] POS_IDLE       = 10'd1023;
    localparam logic [POS_W-1:0] POS_COUNT_HI   = 10'd1;
    localparam logic [POS_W-1:0] POS_COUNT_LO   = 10'd2;
    localparam logic [POS_W-1:0] POS_ADDR_3     = 10'd3;
    localparam logic [POS_W-1:0] POS_ADDR_2     = 10'd4;
    localparam logic [POS_W-1:0] POS_ADDR_1     = 10'd5;
    localparam logic [POS_W-1:0] POS_ADDR_0     = 10'd6;
    localparam logic [POS_W-1:0] POS_TYPE       = 10'd8;
    localparam logic [POS_W-1:0] POS_DATA_START = 10'd9;

    localparam logic [1:0] PHASE_FIRST = 2'd0;
    localparam logic [1:0] PHASE_LAST  = 2'd3;

    localparam logic [UPPER_W-1:0] UPPER_ADDRESS_RESET = 16'h0800;

    typedef struct packed {
        logic [ADDR_W-1:0]  write_address;
        logic [HWORD_W-1:0] write_halfword;
        logic               last_in_record;
    } t_word;

    // Anything outside 0-9 and A-F decodes as zero.
    function automatic logic [3:0] hex_digit(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] diff;
        begin
            diff = 8'd0;
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                diff = c - CHAR_ZERO;
            end else if (c >= CHAR_UPPERA && c <= CHAR_UPPERF) begin
                diff = c - ALPHA_BIAS;
            end
            return diff[3:0];
        end
    endfunction

endpackage

// ----- rtl/core/hrd_if.sv -----
// Valid/ready channel interfaces for characters in and halfwords out.
interface hrd_char_if;
    logic                        valid;
    logic                        ready;
    logic [hrd_pkg::CHAR_W-1:0]  ascii_char;

    modport source (output valid, output ascii_char, input ready);
    modport sink   (input valid, input ascii_char, output ready);
endinterface

interface hrd_word_if;
    logic                        valid;
    logic                        ready;
    logic [hrd_pkg::ADDR_W-1:0]  write_address;
    logic [hrd_pkg::HWORD_W-1:0] write_halfword;
    logic                        last_in_record;

    modport source (output valid, output write_address, output write_halfword,
                    output last_in_record, input ready);
    modport sink   (input valid, input write_address, input write_halfword,
                    input last_in_record, output ready);
endinterface

// ----- rtl/core/hex_record_data_decoder.sv -----
// A halfword is built from the character that completes it and registered into the output stage.
// Throughput: one character per cycle; a two-entry output stage (register plus skid)
// lets input continue while one result waits, and i_char.ready drops only when both are full.
// Reset (synchronous, active low): record position idle until a colon, record state
// cleared, upper address back to 0x0800, output stage empty.
module hex_record_data_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [hrd_pkg::UPPER_W-1:0]   i_cfg_wdata,
    hrd_char_if.sink                      i_char,
    hrd_word_if.source                    o_word
);

    logic [hrd_pkg::UPPER_W-1:0] r_upper_address;
    logic [hrd_pkg::POS_W-1:0]   r_pos,        n_pos;
    logic [hrd_pkg::COUNT_W-1:0] r_byte_count, n_byte_count;
    logic [hrd_pkg::UPPER_W-1:0] r_low_address, n_low_address;
    logic                        r_is_data,    n_is_data;
    logic [hrd_pkg::ACC_W-1:0]   r_acc,        n_acc;
    logic [hrd_pkg::INDEX_W-1:0] r_hw_index,   n_hw_index;

    hrd_pkg::t_word r_out,  n_out;
    hrd_pkg::t_word r_skid, n_skid;
    logic           r_out_valid,  n_out_valid;
    logic           r_skid_valid, n_skid_valid;

    logic                        in_fire;
    logic                        out_fire;
    logic [3:0]                  digit;
    logic [hrd_pkg::POS_W-1:0]   pos_inc;
    logic [hrd_pkg::POS_W-1:0]   data_offset;
    logic [1:0]                  phase;
    logic                        emit;
    hrd_pkg::t_word              result;
    logic [hrd_pkg::COUNT_W-1:0] index_inc;

    assign in_fire  = i_char.valid && i_char.ready;
    assign out_fire = r_out_valid && o_word.ready;

    assign i_char.ready          = !r_skid_valid;
    assign o_word.valid          = r_out_valid;
    assign o_word.write_address  = r_out.write_address;
    assign o_word.write_halfword = r_out.write_halfword;
    assign o_word.last_in_record = r_out.last_in_record;

    assign digit       = hrd_pkg::hex_digit(i_char.ascii_char);
    assign pos_inc     = r_pos + 10'd1;
    assign data_offset = pos_inc - hrd_pkg::POS_DATA_START;
    assign phase       = data_offset[1:0];
    assign index_inc   = {1'b0, r_hw_index} + 8'd1;

    assign result.write_address  = {r_upper_address, r_low_address}
                                 + {24'd0, r_hw_index, 1'b0};
    assign result.write_halfword = {r_acc[3:0], digit, r_acc[11:8], r_acc[7:4]};
    assign result.last_in_record = (index_inc == {1'b0, r_byte_count[7:1]});

    // Record state update for the accepted character.
    always_comb begin
        n_pos         = r_pos;
        n_byte_count  = r_byte_count;
        n_low_address = r_low_address;
        n_is_data     = r_is_data;
        n_acc         = r_acc;
        n_hw_index    = r_hw_index;
        emit          = 1'b0;
        if (in_fire) begin
            priority if (i_char.ascii_char == hrd_pkg::CHAR_COLON) begin
                n_pos      = '0;
                n_is_data  = 1'b0;
                n_hw_index = '0;
                n_acc      = '0;
            end else if (r_pos == hrd_pkg::POS_IDLE) begin
                n_pos = r_pos;
            end else begin
                n_pos = pos_inc;
                priority if (pos_inc == hrd_pkg::POS_COUNT_HI
                             || pos_inc == hrd_pkg::POS_ADDR_3) begin
                    n_acc = {8'd0, digit};
                end else if (pos_inc == hrd_pkg::POS_COUNT_LO) begin
                    n_byte_count = {r_acc[3:0], digit};
                end else if (pos_inc == hrd_pkg::POS_ADDR_2
                             || pos_inc == hrd_pkg::POS_ADDR_1) begin
                    n_acc = {r_acc[7:0], digit};
                end else if (pos_inc == hrd_pkg::POS_ADDR_0) begin
                    n_low_address = {r_acc[11:0], digit};
                end else if (pos_inc == hrd_pkg::POS_TYPE) begin
                    n_is_data = (i_char.ascii_char == hrd_pkg::CHAR_ZERO);
                end else if (pos_inc >= hrd_pkg::POS_DATA_START) begin
                    priority if (phase == hrd_pkg::PHASE_FIRST) begin
                        n_acc = {8'd0, digit};
                    end else if (phase != hrd_pkg::PHASE_LAST) begin
                        n_acc = {r_acc[7:0], digit};
                    end else if (r_is_data && (r_hw_index < r_byte_count[7:1])) begin
                        emit       = 1'b1;
                        n_hw_index = index_inc[hrd_pkg::INDEX_W-1:0];
                    end else begin
                        // drop halfwords past the byte count or outside data records
                        n_hw_index = r_hw_index;
                    end
                end else begin
                    // skip the character before the record type
                    n_acc = r_acc;
                end
            end
        end
    end

    // Output register with one skid entry behind it.
    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = result;
                n_out_valid = emit;
            end
        end else if (emit) begin
            n_skid       = result;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper_address <= hrd_pkg::UPPER_ADDRESS_RESET;
            r_pos           <= hrd_pkg::POS_IDLE;
            r_byte_count    <= '0;
            r_low_address   <= '0;
            r_is_data       <= 1'b0;
            r_acc           <= '0;
            r_hw_index      <= '0;
            r_out_valid     <= 1'b0;
            r_skid_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_upper_address <= i_cfg_wdata;
            end
            r_pos         <= n_pos;
            r_byte_count  <= n_byte_count;
            r_low_address <= n_low_address;
            r_is_data     <= n_is_data;
            r_acc         <= n_acc;
            r_hw_index    <= n_hw_index;
            r_out_valid   <= n_out_valid;
            r_skid_valid  <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_index_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_hw_index} <= {1'b0, r_byte_count[7:1]})
        else $error("halfword index ran past the record length");

    a_result_from_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_char.valid && i_char.ready))
        else $error("result appeared without an accepted character");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos == hrd_pkg::POS_IDLE
         && !(in_fire && i_char.ascii_char == hrd_pkg::CHAR_COLON))
        |=> (r_pos == hrd_pkg::POS_IDLE))
        else $error("left idle without a colon");
`endif

endmodule

// ----- bench/hrd_checker.sv -----
// Checker for the hex record decoder: predicts halfwords from accepted characters and compares.
module hrd_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [hrd_pkg::UPPER_W-1:0] i_cfg_wdata,
    hrd_char_if                         i_char,
    hrd_word_if                         i_word,
    output int                          o_fail_count,
    output int                          o_pending
);

    logic [hrd_pkg::UPPER_W-1:0] upper_address;
    logic [hrd_pkg::POS_W-1:0]   char_pos;
    logic [hrd_pkg::COUNT_W-1:0] byte_count;
    logic [15:0]                 low_address;
    logic                        in_data_record;
    logic [hrd_pkg::ACC_W-1:0]   digits;
    logic [hrd_pkg::INDEX_W-1:0] word_index;
    hrd_pkg::t_word              expected_words[$];
    hrd_pkg::t_word              oldest;
    int                          mismatches = 0;

    function automatic logic [3:0] nibble_of(input logic [hrd_pkg::CHAR_W-1:0] c);
        if (c >= hrd_pkg::CHAR_ZERO && c <= hrd_pkg::CHAR_NINE) begin
            return c[3:0];
        end else if (c >= hrd_pkg::CHAR_UPPERA && c <= hrd_pkg::CHAR_UPPERF) begin
            return c[3:0] + 4'd9;
        end
        return 4'd0;
    endfunction

    task automatic predict_char(input logic [hrd_pkg::CHAR_W-1:0] c);
        logic [3:0]                d;
        logic [hrd_pkg::POS_W-1:0] slot;
        logic [1:0]                phase;
        hrd_pkg::t_word            w;
        if (c == hrd_pkg::CHAR_COLON) begin
            char_pos       = '0;
            in_data_record = 1'b0;
            word_index     = '0;
            digits         = '0;
        end else if (char_pos != hrd_pkg::POS_IDLE) begin
            char_pos = char_pos + 1'b1;
            d        = nibble_of(c);
            slot     = char_pos - hrd_pkg::POS_DATA_START;
            phase    = slot[1:0];
            if (char_pos == hrd_pkg::POS_COUNT_HI || char_pos == hrd_pkg::POS_ADDR_3) begin
                digits = {8'd0, d};
            end else if (char_pos == hrd_pkg::POS_COUNT_LO) begin
                byte_count = {digits[3:0], d};
            end else if (char_pos == hrd_pkg::POS_ADDR_2
                         || char_pos == hrd_pkg::POS_ADDR_1) begin
                digits = {digits[7:0], d};
            end else if (char_pos == hrd_pkg::POS_ADDR_0) begin
                low_address = {digits, d};
            end else if (char_pos == hrd_pkg::POS_TYPE) begin
                in_data_record = (c == hrd_pkg::CHAR_ZERO);
            end else if (char_pos >= hrd_pkg::POS_DATA_START) begin
                if (phase == hrd_pkg::PHASE_FIRST) begin
                    digits = {8'd0, d};
                end else if (phase != hrd_pkg::PHASE_LAST) begin
                    digits = {digits[7:0], d};
                end else if (in_data_record && word_index < byte_count[7:1]) begin
                    // digits d0 d1 d2 d3 become d2 d3 d0 d1: first byte goes low
                    w.write_address  = {upper_address, low_address}
                                     + {24'd0, word_index, 1'b0};
                    w.write_halfword = {digits[3:0], d, digits[11:8], digits[7:4]};
                    w.last_in_record = ({1'b0, word_index} + 8'd1)
                                       == {1'b0, byte_count[7:1]};
                    expected_words.push_back(w);
                    word_index = word_index + 1'b1;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            upper_address  = hrd_pkg::UPPER_ADDRESS_RESET;
            char_pos       = hrd_pkg::POS_IDLE;
            byte_count     = '0;
            low_address    = '0;
            in_data_record = 1'b0;
            digits         = '0;
            word_index     = '0;
            expected_words.delete();
        end else begin
            if (i_word.valid && i_word.ready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected halfword: write_address %h write_halfword %h",
                           i_word.write_address, i_word.write_halfword);
                    mismatches++;
                end else begin
                    oldest = expected_words.pop_front();
                    if (i_word.write_address !== oldest.write_address) begin
                        $error("write_address: expected %h, got %h",
                               oldest.write_address, i_word.write_address);
                        mismatches++;
                    end
                    if (i_word.write_halfword !== oldest.write_halfword) begin
                        $error("write_halfword: expected %h, got %h",
                               oldest.write_halfword, i_word.write_halfword);
                        mismatches++;
                    end
                    if (i_word.last_in_record !== oldest.last_in_record) begin
                        $error("last_in_record: expected %b, got %b",
                               oldest.last_in_record, i_word.last_in_record);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_we) begin
                upper_address = i_cfg_wdata;
            end
            if (i_char.valid && i_char.ready) begin
                predict_char(i_char.ascii_char);
            end
        end
        o_pending    <= expected_words.size();
        o_fail_count <= mismatches;
    end

endmodule

// ----- bench/tb_top.sv -----
// Top of the hex record decoder testbench: clock, reset, record stimulus and verdict.
module tb_top;

    typedef logic [hrd_pkg::CHAR_W-1:0]  t_char;
    typedef logic [hrd_pkg::UPPER_W-1:0] t_upper;

    localparam t_char       CHAR_CR      = 8'd13;
    localparam t_char       CHAR_LF      = 8'd10;
    localparam t_char       CHAR_LOWER_A = 8'd97;
    localparam int unsigned PHASE_CHARS  = 250;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    t_upper            i_cfg_wdata;
    int                fail_count;
    int                pending;
    int                gap_max;
    int unsigned       chars_sent;
    t_char             record_text[$];

    hrd_char_if char_bus();
    hrd_word_if word_bus();

    always #6 i_clk = ~i_clk;

    hex_record_data_decoder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_char      (char_bus),
        .o_word      (word_bus)
    );

    hrd_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_char       (char_bus),
        .i_word       (word_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic t_char hex_of(input int unsigned v);
        logic [3:0] n;
        n = v[3:0];
        return (n < 4'd10) ? hrd_pkg::CHAR_ZERO + n : hrd_pkg::ALPHA_BIAS + n;
    endfunction

    function automatic t_char any_but_colon();
        t_char c;
        do begin
            c = t_char'($urandom_range(0, 255));
        end while (c == hrd_pkg::CHAR_COLON);
        return c;
    endfunction

    // Mostly clean hex digits, now and then lower case or junk.
    function automatic t_char data_digit();
        int unsigned r;
        r = $urandom_range(0, 31);
        if (r == 0) begin
            return any_but_colon();
        end else if (r == 1) begin
            return t_char'(CHAR_LOWER_A + $urandom_range(0, 5));
        end
        return hex_of($urandom_range(0, 15));
    endfunction

    task automatic send_char(input t_char c);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            char_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        char_bus.valid      <= 1'b1;
        char_bus.ascii_char <= c;
        do @(posedge i_clk); while (!char_bus.ready);
        chars_sent++;
    endtask

    task automatic send_string(input string s);
        for (int k = 0; k < s.len(); k++) begin
            send_char(s[k]);
        end
    endtask

    task automatic send_record_text();
        foreach (record_text[k]) begin
            send_char(record_text[k]);
        end
    endtask

    task automatic push_hex(input int unsigned v, input int ndigits);
        for (int k = ndigits - 1; k >= 0; k--) begin
            record_text.push_back(hex_of(v >> (4 * k)));
        end
    endtask

    task automatic build_record(input int unsigned count, input int unsigned addr,
                                input t_char type_ch, input int unsigned nbytes);
        record_text.push_back(hrd_pkg::CHAR_COLON);
        push_hex(count, 2);
        push_hex(addr, 4);
        record_text.push_back(($urandom_range(0, 7) == 0) ? any_but_colon()
                                                          : hrd_pkg::CHAR_ZERO);
        record_text.push_back(type_ch);
        repeat (2 * nbytes) record_text.push_back(data_digit());
        push_hex($urandom_range(0, 255), 2);
        if ($urandom_range(0, 1)) begin
            record_text.push_back(CHAR_CR);
            record_text.push_back(CHAR_LF);
        end
    endtask

    task automatic random_record();
        int unsigned kind;
        int unsigned count;
        int unsigned addr;
        int unsigned cut;
        t_char       type_ch;
        record_text.delete();
        gap_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
        kind    = $urandom_range(0, 99);
        count   = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(0, 16);
        addr    = ($urandom_range(0, 7) == 0) ? $urandom_range(16'hFFF0, 16'hFFFF)
                                              : $urandom_range(0, 16'hFFFF);
        if (kind < 65) begin
            build_record(count, addr, hrd_pkg::CHAR_ZERO, count);
        end else if (kind < 77) begin
            type_ch = $urandom_range(0, 1)
                    ? t_char'(hrd_pkg::CHAR_ZERO + $urandom_range(1, 5))
                    : any_but_colon();
            build_record(count, addr, type_ch, count);
        end else if (kind < 89) begin
            // data length may disagree with the byte count
            build_record(count, addr, hrd_pkg::CHAR_ZERO, $urandom_range(0, count + 3));
        end else if (kind < 95) begin
            build_record(count, addr, hrd_pkg::CHAR_ZERO, count);
            cut = $urandom_range(1, record_text.size() - 1);
            repeat (cut) void'(record_text.pop_back());
        end else begin
            repeat ($urandom_range(1, 8)) record_text.push_back(t_char'($urandom_range(0, 255)));
        end
        send_record_text();
    endtask

    task automatic wait_drained();
        char_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        // a character that completes nothing may still be in flight
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_upper(input t_upper value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Result side: random stalls, quiet stretches, and one long hold-off.
    initial begin : result_side
        int stall;
        int taken;
        int rx_max;
        word_bus.ready = 1'b0;
        taken  = 0;
        rx_max = 5;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = $urandom_range(0, rx_max);
            if (stall > 0) begin
                word_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            word_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!word_bus.valid);
            taken++;
            if (taken % 32 == 0) begin
                rx_max = $urandom_range(0, 1) ? 5 : 0;
            end
            if (taken == 60) begin
                // hold long enough to fill the output stage and back up the input
                word_bus.ready <= 1'b0;
                repeat (200) @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_wdata         = '0;
        char_bus.valid      = 1'b0;
        char_bus.ascii_char = '0;
        gap_max             = 5;
        chars_sent          = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle junk before any colon
        send_char(8'h00);
        send_char(8'hFF);
        send_string("Z7");
        // address carry into the upper half, all-zero and all-one digits
        send_string(":04FFFF0000FFFF00E3\r\n");
        // odd count, lower case and non-hex digits, trailing byte dropped
        send_string(":03123400ab9FG7C1\r\n");
        // end-of-file and extended-address records
        send_string(":00000001FF\r\n");
        send_string(":020000040800F2\r\n");
        // colon inside a record restarts it
        send_string(":0400:0200100012AB7F");
        // zero byte count, then an ignored position 7
        send_string(":000000001234");
        send_string(":0200207031F0");

        write_upper(16'hFFFF);
        send_string(":06FFFC0012345678ABCD00");
        write_upper(16'h0000);
        send_string(":020000000000");

        for (int p = 0; p < 4; p++) begin
            write_upper((p == 3) ? hrd_pkg::UPPER_ADDRESS_RESET
                                 : t_upper'($urandom_range(0, 16'hFFFF)));
            if (p == 1) begin
                // overlong line: full 255-byte record then run past the idle position
                record_text.delete();
                gap_max = 0;
                build_record(255, $urandom_range(0, 16'hFFFF), hrd_pkg::CHAR_ZERO, 255);
                while (record_text.size() < 1040) record_text.push_back(data_digit());
                send_record_text();
            end
            chars_sent = 0;
            while (chars_sent < PHASE_CHARS) random_record();
        end

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    initial begin : watchdog
        #(12 * 200000);
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
